/* rtl/core/dss_pkg.sv */
// ----------------------------------------------------------------------------
// dss_pkg: shared types and constants
// Histogram sizing, divider sizing, register map, codes and the sequencer
// state type of the Doppler static/dynamic split block.
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int NUM_BINS     = 512;
  localparam int BIN_W        = $clog2(NUM_BINS);
  localparam int MAX_POINTS   = 65535;
  localparam int PT_W         = $clog2(MAX_POINTS + 1);
  localparam int BELOW_GROUND = 256;
  localparam int ABOVE_GROUND = 768;

  // shared restoring divider
  localparam int DIV_W     = 33;
  localparam int DCNT_W    = 6;
  localparam int BIN_ITER  = 16;
  localparam int MEAN_ITER = 33;

  // register map
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_BUCKET_WIDTH     = 3'd0;
  localparam logic [2:0] REG_GROUND_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_KEEP_DYNAMIC     = 3'd2;
  localparam logic [2:0] REG_FAR_RANGE        = 3'd3;
  localparam logic [2:0] REG_STATIC_TOLERANCE = 3'd4;

  localparam logic REQ_ACCUM    = 1'b0;
  localparam logic REQ_CLASSIFY = 1'b1;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_POINT   = 1'b1;

  typedef enum logic [1:0] {
    CLS_STATIC  = 2'd0,
    CLS_DYNAMIC = 2'd1,
    CLS_DROPPED = 2'd2
  } class_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BDIV,
    ST_BRD,
    ST_BWR,
    ST_SCAN,
    ST_TAIL,
    ST_MSET,
    ST_MDIV,
    ST_SUM,
    ST_CLS
  } state_e;

  typedef struct packed {
    logic [15:0]        cnt;
    logic [15:0]        far;
    logic signed [31:0] sum;
  } hist_t;

endpackage

/* rtl/core/dss_stream_if.sv */
// ----------------------------------------------------------------------------
// dss_stream_if: point and result channels
// Valid/ready channels carrying one point word in and one result word out.
// ----------------------------------------------------------------------------
interface dss_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [15:0] velocity;
  logic [15:0]        range_dist;
  logic signed [15:0] height;
  logic               frame_last;

  modport source (output valid, req_type, velocity, range_dist, height, frame_last,
                  input ready);
  modport sink (input valid, req_type, velocity, range_dist, height, frame_last,
                output ready);
endinterface

interface dss_out_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [1:0]         point_class;
  logic signed [15:0] reference_velocity;
  logic               reference_found;

  modport source (output valid, result_kind, point_class, reference_velocity,
                  reference_found, input ready);
  modport sink (input valid, result_kind, point_class, reference_velocity,
                reference_found, output ready);
endinterface

/* rtl/core/doppler_static_dynamic_split_top.sv */
// ----------------------------------------------------------------------------
// doppler_static_dynamic_split_top: Doppler velocity histogram and point split
// Accumulate words bin velocities into a 512-entry histogram; the frame's last
// word picks the bin with the most far points and reports its mean velocity.
// Classify words are split into static, dynamic or dropped.
//
// Channels: in_i takes point words, out_o gives result words, both valid/ready.
// Registers must be written over the APB port only while the block is idle;
// the block itself does not enforce this.
// Per word, with one shift-subtract divider shared by bin and mean:
//   classify word: registered, classified in ST_CLS and loaded into the
//   result register once it is free; the next word waits until then.
//   accumulate word: 16 divider steps for the bin, then a histogram read
//   and write back; no result. A frame's last word adds a clearing scan of
//   all 512 entries, then, given a far bin, 33 divider steps for the mean.
// in_i.ready is high only while the sequencer is idle.
// Reset: config takes its defaults, the reference goes to 0 / not found, and
// a pass over all 512 entries zeroes the histogram before any word is taken.
// A stalled receiver holds the result word; the block takes the next point
// word meanwhile but waits to emit its result until the word is taken.
// ----------------------------------------------------------------------------
module doppler_static_dynamic_split_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  dss_in_if.sink                      in_i,
  dss_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dss_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import dss_pkg::*;

  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

  state_e state_q, state_d;

  // configuration
  logic [14:0]        bw_q;
  logic signed [15:0] gh_q;
  logic               kd_q;
  logic [15:0]        far_q;
  logic [14:0]        tol_q;
  logic [2:0]         reg_idx;

  // control state
  logic [BIN_W-1:0]   scan_q;
  logic               sv_q;
  logic [DCNT_W-1:0]  cnt_q;
  logic [PT_W-1:0]    points_q;
  logic signed [15:0] ref_q;
  logic               found_q;
  logic               out_valid_q;

  // payload
  logic signed [15:0] vel_q;
  logic [15:0]        rng_q;
  logic signed [15:0] hgt_q;
  logic               last_q;
  logic [BIN_W-1:0]   idx_q;
  logic [DIV_W-1:0]   quo_q;
  logic [15:0]        rem_q;
  logic [15:0]        div_q;
  logic               neg_q;
  logic [15:0]        best_far_q;
  logic [15:0]        best_cnt_q;
  logic signed [31:0] best_sum_q;
  logic               out_kind_q;
  class_e             out_cls_q;
  logic signed [15:0] out_ref_q;
  logic               out_found_q;

  // histogram memory
  hist_t              mem_q [NUM_BINS];
  hist_t              rd_q;
  logic               mem_we;
  logic [BIN_W-1:0]   mem_wa;
  hist_t              mem_wd;
  logic [BIN_W-1:0]   mem_ra;

  logic               in_acc;
  logic               out_free;
  logic               out_load;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // ---- APB ----
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_comb begin
    case (reg_idx)
      REG_BUCKET_WIDTH:     prdata = {17'd0, bw_q};
      REG_GROUND_HEIGHT:    prdata = {{16{gh_q[15]}}, gh_q};
      REG_KEEP_DYNAMIC:     prdata = {31'd0, kd_q};
      REG_FAR_RANGE:        prdata = {16'd0, far_q};
      REG_STATIC_TOLERANCE: prdata = {17'd0, tol_q};
      default:              prdata = 32'd0;
    endcase
  end

  // ---- shared divider step ----
  logic [16:0] rem_sh;
  logic        sub_ok;
  logic [15:0] rem_step;
  logic [DIV_W-1:0] quo_step;

  assign rem_sh   = {rem_q, quo_q[DIV_W-1]};
  assign sub_ok   = rem_sh >= {1'b0, div_q};
  assign rem_step = sub_ok ? 16'(rem_sh - {1'b0, div_q}) : rem_sh[15:0];
  assign quo_step = {quo_q[DIV_W-2:0], sub_ok};

  // ---- divider load values ----
  logic [14:0] bw_eff;
  logic [15:0] vmag_in;
  logic [31:0] smag;
  logic [DIV_W-1:0] mean_dvd;

  assign bw_eff   = (bw_q == 15'd0) ? 15'd1 : bw_q;
  assign vmag_in  = in_i.velocity[15] ? 16'(~in_i.velocity + 16'sd1) : in_i.velocity;
  assign smag     = best_sum_q[31] ? 32'(~best_sum_q + 32'sd1) : best_sum_q;
  assign mean_dvd = {1'b0, smag} + DIV_W'(best_cnt_q >> 1);

  // ---- bin index from quotient ----
  logic [16:0]        qmag;
  logic signed [17:0] qs;
  logic signed [17:0] idx_s;
  logic [BIN_W-1:0]   idx_new;

  assign qmag  = {1'b0, quo_q[15:0]} + 17'(neg_q && (rem_q != 16'd0));
  assign qs    = neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  assign idx_s = qs + 18'sd256 + 18'(NUM_BINS / 2) - 18'sd256;

  always_comb begin
    if (idx_s < 18'sd0) begin
      idx_new = '0;
    end else if (idx_s > 18'(NUM_BINS - 1)) begin
      idx_new = LAST_BIN;
    end else begin
      idx_new = idx_s[BIN_W-1:0];
    end
  end

  // ---- mean from quotient ----
  logic signed [15:0] mean_val;

  always_comb begin
    if (!neg_q) begin
      mean_val = (quo_q > DIV_W'(32767)) ? 16'sh7fff : quo_q[15:0];
    end else begin
      mean_val = (quo_q > DIV_W'(32768)) ? 16'sh8000 : 16'(~quo_q[15:0] + 16'd1);
    end
  end

  // ---- histogram update ----
  logic signed [32:0] sum_ext;
  hist_t              upd;

  assign sum_ext = 33'(rd_q.sum) + 33'(vel_q);

  always_comb begin
    upd.cnt = (rd_q.cnt == 16'hffff) ? rd_q.cnt : rd_q.cnt + 16'd1;
    upd.far = (rng_q > far_q && rd_q.far != 16'hffff) ? rd_q.far + 16'd1 : rd_q.far;
    if (sum_ext > 33'sh0_7fff_ffff) begin
      upd.sum = 32'sh7fff_ffff;
    end else if (sum_ext < -33'sh0_8000_0000) begin
      upd.sum = 32'sh8000_0000;
    end else begin
      upd.sum = sum_ext[31:0];
    end
  end

  // ---- classification ----
  logic signed [16:0] dv;
  logic [16:0]        adv;
  logic signed [17:0] h_lo;
  logic signed [17:0] h_hi;
  logic signed [17:0] h_ext;
  class_e             cls;

  assign dv    = 17'(vel_q) - 17'(ref_q);
  assign adv   = dv[16] ? 17'(-dv) : dv;
  assign h_lo  = 18'(gh_q) - 18'(BELOW_GROUND);
  assign h_hi  = 18'(gh_q) + 18'(ABOVE_GROUND);
  assign h_ext = 18'(hgt_q);

  always_comb begin
    if (adv <= {2'b00, tol_q}) begin
      cls = CLS_STATIC;
    end else if (kd_q && h_ext > h_lo && h_ext < h_hi) begin
      cls = CLS_DYNAMIC;
    end else begin
      cls = CLS_DROPPED;
    end
  end

  // ---- next state ----
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (scan_q == LAST_BIN) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.req_type == REQ_CLASSIFY) begin
            state_d = ST_CLS;
          end else if (points_q < PT_W'(MAX_POINTS)) begin
            state_d = ST_BDIV;
          end else if (in_i.frame_last) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_BDIV: if (cnt_q == '0) state_d = ST_BRD;
      ST_BRD:  state_d = ST_BWR;
      ST_BWR:  state_d = last_q ? ST_SCAN : ST_IDLE;
      ST_SCAN: if (scan_q == LAST_BIN) state_d = ST_TAIL;
      ST_TAIL: state_d = ST_MSET;
      ST_MSET: state_d = (best_far_q == 16'd0) ? ST_SUM : ST_MDIV;
      ST_MDIV: if (cnt_q == '0) state_d = ST_SUM;
      ST_SUM:  if (out_free) state_d = ST_IDLE;
      ST_CLS:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_CLEAR;
    endcase
  end

  // ---- sequencer outputs ----
  always_comb begin
    in_i.ready = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = scan_q;
    mem_wd     = '0;
    mem_ra     = scan_q;
    out_load   = 1'b0;
    case (state_q)
      ST_CLEAR: mem_we = 1'b1;
      ST_IDLE:  in_i.ready = 1'b1;
      ST_BRD:   mem_ra = idx_q;
      ST_BWR: begin
        mem_we = 1'b1;
        mem_wa = idx_q;
        mem_wd = upd;
      end
      ST_SCAN:  mem_we = 1'b1;
      ST_SUM:   out_load = out_free;
      ST_CLS:   out_load = out_free;
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // ---- control registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      scan_q      <= '0;
      sv_q        <= 1'b0;
      cnt_q       <= '0;
      points_q    <= '0;
      ref_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      bw_q        <= 15'd205;
      gh_q        <= '0;
      kd_q        <= 1'b1;
      far_q       <= 16'd5120;
      tol_q       <= 15'd205;
    end else begin
      state_q <= state_d;
      sv_q    <= (state_q == ST_SCAN);

      if (psel && penable && pwrite) begin
        case (reg_idx)
          REG_BUCKET_WIDTH:     bw_q  <= pwdata[14:0];
          REG_GROUND_HEIGHT:    gh_q  <= pwdata[15:0];
          REG_KEEP_DYNAMIC:     kd_q  <= pwdata[0];
          REG_FAR_RANGE:        far_q <= pwdata[15:0];
          REG_STATIC_TOLERANCE: tol_q <= pwdata[14:0];
          default: ;
        endcase
      end

      if (state_q == ST_CLEAR || state_q == ST_SCAN) begin
        scan_q <= scan_q + 1'b1;
      end

      if (state_q == ST_IDLE && in_acc) begin
        cnt_q <= DCNT_W'(BIN_ITER);
      end else if (state_q == ST_MSET) begin
        cnt_q <= DCNT_W'(MEAN_ITER);
      end else if ((state_q == ST_BDIV || state_q == ST_MDIV) && cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end

      if (state_q == ST_BWR) begin
        points_q <= points_q + 1'b1;
      end else if (state_q == ST_TAIL) begin
        points_q <= '0;
      end

      if (state_q == ST_MSET && best_far_q == 16'd0) begin
        ref_q   <= '0;
        found_q <= 1'b0;
      end else if (state_q == ST_MDIV && cnt_q == '0) begin
        ref_q   <= mean_val;
        found_q <= 1'b1;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---- datapath registers ----
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_acc) begin
      vel_q  <= in_i.velocity;
      rng_q  <= in_i.range_dist;
      hgt_q  <= in_i.height;
      last_q <= in_i.frame_last;
      neg_q  <= in_i.velocity[15];
      quo_q  <= {vmag_in, 17'd0};
      rem_q  <= '0;
      div_q  <= {1'b0, bw_eff};
    end else if (state_q == ST_MSET) begin
      neg_q  <= best_sum_q[31];
      quo_q  <= mean_dvd;
      rem_q  <= '0;
      div_q  <= best_cnt_q;
    end else if ((state_q == ST_BDIV || state_q == ST_MDIV) && cnt_q != '0) begin
      quo_q  <= quo_step;
      rem_q  <= rem_step;
    end

    if (state_q == ST_BDIV) begin
      idx_q <= idx_new;
    end

    if (state_q == ST_IDLE || state_q == ST_BWR) begin
      best_far_q <= '0;
      best_cnt_q <= '0;
      best_sum_q <= '0;
    end else if (sv_q && rd_q.far > best_far_q) begin
      best_far_q <= rd_q.far;
      best_cnt_q <= rd_q.cnt;
      best_sum_q <= rd_q.sum;
    end

    if (out_load) begin
      out_kind_q  <= (state_q == ST_CLS) ? KIND_POINT : KIND_SUMMARY;
      out_cls_q   <= (state_q == ST_CLS) ? cls : CLS_STATIC;
      out_ref_q   <= ref_q;
      out_found_q <= found_q;
    end
  end

  // ---- histogram memory ----
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_q <= mem_q[mem_ra];
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.result_kind        = out_kind_q;
  assign out_o.point_class        = out_cls_q;
  assign out_o.reference_velocity = out_ref_q;
  assign out_o.reference_found    = out_found_q;

`ifndef SYNTHESIS
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !mem_we)
    else $error("histogram written while idle");

  a_classify_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.req_type == REQ_CLASSIFY |=> state_q == ST_CLS)
    else $error("classify word did not go to classification");

  a_ref_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !found_q |-> ref_q == 16'sd0)
    else $error("reference nonzero without a far bin");

  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN && scan_q == '0 |-> best_far_q == 16'd0)
    else $error("scan started with stale best bin");
`endif

endmodule
